// File: design/jacobi_tile_sweep_assert.svh
// ----------------------------------------------------------------------------
// jacobi_tile_sweep_assert.svh
// Assertion macros for the Jacobi tile sweep block. They use the clock and
// reset names of the including module and are muted while reset is high.
// ----------------------------------------------------------------------------
`ifndef JACOBI_TILE_SWEEP_ASSERT_SVH
`define JACOBI_TILE_SWEEP_ASSERT_SVH

// same-cycle implication
`define JTS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define JTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/jts_pkg.sv
// ----------------------------------------------------------------------------
// jts_pkg
// Shared sizes, codes and stage types of the Jacobi tile sweep block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jts_pkg;

   // tile geometry
   localparam int TILE_SIZE  = 16;
   localparam int IDX_W      = $clog2(TILE_SIZE);
   localparam int CELLS      = TILE_SIZE * TILE_SIZE;
   localparam int TILE_AW    = 1 + 2 * IDX_W;      // bank, row, column
   localparam int TILE_DEPTH = 2 ** TILE_AW;
   localparam int HALO_AW    = 2 + IDX_W;          // side, position
   localparam int HALO_DEPTH = 2 ** HALO_AW;
   localparam int LINE_LEN   = 2 * TILE_SIZE + 1;  // window over three rows

   // sweep sequencer: every cell is read once, results trail by one row
   localparam int SWEEP_LEN = CELLS + TILE_SIZE;
   localparam int CNT_W     = $clog2(SWEEP_LEN + 1);
   localparam logic [CNT_W-1:0] SEQ_END   = CNT_W'(SWEEP_LEN);
   localparam logic [CNT_W-1:0] SEQ_CELLS = CNT_W'(CELLS);
   localparam logic [CNT_W-1:0] SEQ_LAG   = CNT_W'(TILE_SIZE);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(TILE_SIZE - 1);

   // arithmetic
   localparam int VAL_W = 16;
   localparam int SUM_W = VAL_W + 3;               // five values
   localparam logic [VAL_W-1:0] TOL_RESET = VAL_W'(3);

   // divide by five: multiply by ceil(2^k / 5), take the top bits
   localparam int RECIP_SHIFT = SUM_W + 3;
   localparam int RECIP_W     = RECIP_SHIFT - 2;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'((2 ** RECIP_SHIFT) / 5 + 1);

   typedef enum logic [1:0] {
      CMD_WRITE_CELL = 2'd0,
      CMD_WRITE_HALO = 2'd1,
      CMD_SWEEP      = 2'd2,
      CMD_READ_CELL  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SIDE_NORTH = 2'd0,
      SIDE_SOUTH = 2'd1,
      SIDE_EAST  = 2'd2,
      SIDE_WEST  = 2'd3
   } side_type;

   // one cell in flight through the sweep pipeline
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } pos_type;

   // sequencer token: a tile read was issued, and maybe a cell to compute
   typedef struct packed {
      logic    push;
      pos_type pos;
   } tok_type;

   typedef struct packed {
      logic               en;
      logic [HALO_AW-1:0] v_addr;
      logic [HALO_AW-1:0] h_addr;
   } halo_rd_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      logic [VAL_W-1:0] data;
   } cell_wr_type;

   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] worst;
   } done_type;

endpackage

`default_nettype wire

// File: design/jts_channels.sv
// ----------------------------------------------------------------------------
// jts_channels
// Request and response channels of the Jacobi tile sweep block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jts_req_if import jts_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       command;
   logic [3:0]       row;
   logic [3:0]       column;
   logic [1:0]       side;
   logic [3:0]       halo_pos;
   logic [VAL_W-1:0] value;

   modport source (output valid, command, row, column, side, halo_pos, value,
                   input ready);
   modport sink   (input valid, command, row, column, side, halo_pos, value,
                   output ready);
endinterface

interface jts_rsp_if import jts_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] read_value;
   logic [VAL_W-1:0] max_change;
   logic             converged;
   logic [VAL_W-1:0] sweep_count;

   modport source (output valid, read_value, max_change, converged, sweep_count,
                   input ready);
   modport sink   (input valid, read_value, max_change, converged, sweep_count,
                   output ready);
endinterface

`default_nettype wire

// File: design/jts_stencil.sv
// ----------------------------------------------------------------------------
// jts_stencil
// Sweep datapath: three-row window over the streamed old bank, halo
// substitution at the edges, five-point sum, divide by five, change tracking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jts_stencil import jts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  tok_type          tok,
   input  logic [VAL_W-1:0] tile_rdata,
   input  logic [VAL_W-1:0] halo_v_data,
   input  logic [VAL_W-1:0] halo_h_data,
   output halo_rd_type      halo_rd,
   output cell_wr_type      cell_wr,
   output done_type         done
);

   tok_type            s1_ff;
   pos_type            s2_ff, s3_ff, s4_ff;
   logic [VAL_W-1:0]   line_ff [LINE_LEN];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [VAL_W-1:0]   old3_ff, old4_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [VAL_W-1:0]   max_ff, max_in;

   side_type           v_side, h_side;
   logic [VAL_W-1:0]   up, down, left, right, self_v;
   logic [VAL_W-1:0]   nv, diff, worst_now;

   // stage 1: halo fetch for the cell; north/south by column, west/east by row
   always_comb begin
      v_side = (s1_ff.pos.row == '0) ? SIDE_NORTH : SIDE_SOUTH;
      h_side = (s1_ff.pos.col == '0) ? SIDE_WEST : SIDE_EAST;
      halo_rd.en     = s1_ff.pos.valid;
      halo_rd.v_addr = {v_side, s1_ff.pos.col};
      halo_rd.h_addr = {h_side, s1_ff.pos.row};
   end

   // window: newest at tap 0, the cell itself one row back
   always_ff @(posedge clock) begin
      if (s1_ff.push || s1_ff.pos.valid) begin
         line_ff[0] <= tile_rdata;
         for (int i = 1; i < LINE_LEN; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   // stage 2: neighbours, halo at the tile edges, then the sum
   always_comb begin
      self_v = line_ff[TILE_SIZE];
      up     = (s2_ff.row == '0)      ? halo_v_data : line_ff[2*TILE_SIZE];
      down   = (s2_ff.row == IDX_LAST) ? halo_v_data : line_ff[0];
      left   = (s2_ff.col == '0)      ? halo_h_data : line_ff[TILE_SIZE+1];
      right  = (s2_ff.col == IDX_LAST) ? halo_h_data : line_ff[TILE_SIZE-1];
      sum_in = SUM_W'(self_v) + SUM_W'(up) + SUM_W'(down) + SUM_W'(left)
             + SUM_W'(right);
   end

   // stage 3: reciprocal multiply
   assign prod_in = PROD_W'(sum_ff) * PROD_W'(RECIP_V);

   // stage 4: quotient, change, write-back and running maximum
   always_comb begin
      nv        = prod_ff[RECIP_SHIFT +: VAL_W];
      diff      = (nv > old4_ff) ? (nv - old4_ff) : (old4_ff - nv);
      worst_now = (diff > max_ff) ? diff : max_ff;
      if (s4_ff.valid) begin
         max_in = s4_ff.last ? '0 : worst_now;
      end else begin
         max_in = max_ff;
      end
      cell_wr.valid = s4_ff.valid;
      cell_wr.row   = s4_ff.row;
      cell_wr.col   = s4_ff.col;
      cell_wr.data  = nv;
      done.valid    = s4_ff.valid && s4_ff.last;
      done.worst    = worst_now;
   end

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff  <= '0;
         s2_ff  <= '0;
         s3_ff  <= '0;
         s4_ff  <= '0;
         max_ff <= '0;
      end else begin
         s1_ff  <= tok;
         s2_ff  <= s1_ff.pos;
         s3_ff  <= s2_ff;
         s4_ff  <= s3_ff;
         max_ff <= max_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      old3_ff <= self_v;
      prod_ff <= prod_in;
      old4_ff <= old3_ff;
   end

endmodule

`default_nettype wire

// File: design/jacobi_tile_sweep.sv
// ----------------------------------------------------------------------------
// jacobi_tile_sweep
// One double-buffered tile of a five-point Jacobi relaxation with halos.
// Cell and halo writes and cell reads: one item per cycle, result the next,
// while no sweep runs and the response is taken. A sweep's length is set by
// the one tile memory read port streaming a cell a cycle.
// Reset clears control, bank select, sweep count and sets tolerance to 3;
// tile and halo memories keep their contents and must be written before use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "jacobi_tile_sweep_assert.svh"

module jacobi_tile_sweep import jts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   jts_req_if.sink          req_if,
   jts_rsp_if.source        rsp_if,
   input  logic             csr_write_enable,
   input  logic [VAL_W-1:0] csr_write_data
);

   typedef enum logic {ST_IDLE, ST_SWEEP} state_type;

   state_type        state_ff, state_in;
   logic             bank_ff, bank_in;
   logic [VAL_W-1:0] sweeps_ff, sweeps_in;
   logic [VAL_W-1:0] tol_ff, tol_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_max_ff, rsp_max_in;
   logic             rsp_conv_ff, rsp_conv_in;
   logic             rsp_is_read_ff, rsp_is_read_in;
   logic [CNT_W-1:0] seq_ff, seq_in;
   logic [IDX_W-1:0] rrow_ff, rrow_in, rcol_ff, rcol_in;
   logic [IDX_W-1:0] krow_ff, krow_in, kcol_ff, kcol_in;

   logic [VAL_W-1:0] tile_mem [TILE_DEPTH];
   logic [VAL_W-1:0] halo_mem [HALO_DEPTH];
   logic [VAL_W-1:0] tile_rdata_ff, halo_v_ff, halo_h_ff;

   cmd_type          cmd;
   logic             req_accept, cell_in_range, halo_in_range, issuing;
   logic [IDX_W-1:0] cell_row, cell_col;
   tok_type          tok;
   halo_rd_type      halo_rd;
   cell_wr_type      cell_wr;
   done_type         done;
   logic             tile_rd_en, tile_wr_en, halo_wr_en;
   logic [TILE_AW-1:0] tile_rd_addr, tile_wr_addr;
   logic [VAL_W-1:0] tile_wr_data;
   logic [HALO_AW-1:0] halo_wr_addr;

   // request decode
   always_comb begin
      cmd           = cmd_type'(req_if.command);
      cell_in_range = (int'(req_if.row) < TILE_SIZE) && (int'(req_if.column) < TILE_SIZE);
      halo_in_range = int'(req_if.halo_pos) < TILE_SIZE;
      cell_row      = IDX_W'(req_if.row);
      cell_col      = IDX_W'(req_if.column);
      req_if.ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
      req_accept    = req_if.valid && req_if.ready;
   end

   // sweep sequencer: reads run one row ahead of the cells being computed
   always_comb begin
      issuing       = (state_ff == ST_SWEEP) && (seq_ff != SEQ_END);
      tok.push      = issuing && (seq_ff < SEQ_CELLS);
      tok.pos.valid = issuing && (seq_ff >= SEQ_LAG);
      tok.pos.last  = tok.pos.valid && (krow_ff == IDX_LAST) && (kcol_ff == IDX_LAST);
      tok.pos.row   = krow_ff;
      tok.pos.col   = kcol_ff;
   end

   jts_stencil u_stencil (
      .clock       (clock),
      .reset       (reset),
      .tok         (tok),
      .tile_rdata  (tile_rdata_ff),
      .halo_v_data (halo_v_ff),
      .halo_h_data (halo_h_ff),
      .halo_rd     (halo_rd),
      .cell_wr     (cell_wr),
      .done        (done)
   );

   // tile memory ports: the sweep reads the current bank and writes the other
   always_comb begin
      tile_rd_en   = (req_accept && (cmd == CMD_READ_CELL)) || tok.push;
      tile_rd_addr = (state_ff == ST_SWEEP) ? {bank_ff, rrow_ff, rcol_ff}
                                            : {bank_ff, cell_row, cell_col};
      tile_wr_en   = (req_accept && (cmd == CMD_WRITE_CELL) && cell_in_range)
                   || cell_wr.valid;
      tile_wr_addr = cell_wr.valid ? {~bank_ff, cell_wr.row, cell_wr.col}
                                   : {bank_ff, cell_row, cell_col};
      tile_wr_data = cell_wr.valid ? cell_wr.data : req_if.value;
      halo_wr_en   = req_accept && (cmd == CMD_WRITE_HALO) && halo_in_range;
      halo_wr_addr = {req_if.side, IDX_W'(req_if.halo_pos)};
   end

   always_ff @(posedge clock) begin
      if (tile_wr_en) begin
         tile_mem[tile_wr_addr] <= tile_wr_data;
      end
      if (tile_rd_en) begin
         tile_rdata_ff <= tile_mem[tile_rd_addr];
      end
   end

   // halo memory: one write port, two read ports
   always_ff @(posedge clock) begin
      if (halo_wr_en) begin
         halo_mem[halo_wr_addr] <= req_if.value;
      end
      if (halo_rd.en) begin
         halo_v_ff <= halo_mem[halo_rd.v_addr];
         halo_h_ff <= halo_mem[halo_rd.h_addr];
      end
   end

   // next state and response
   always_comb begin
      state_in       = state_ff;
      bank_in        = bank_ff;
      sweeps_in      = sweeps_ff;
      tol_in         = csr_write_enable ? csr_write_data : tol_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_max_in     = rsp_max_ff;
      rsp_conv_in    = rsp_conv_ff;
      rsp_is_read_in = rsp_is_read_ff;
      seq_in         = seq_ff;
      rrow_in        = rrow_ff;
      rcol_in        = rcol_ff;
      krow_in        = krow_ff;
      kcol_in        = kcol_ff;

      if (req_accept) begin
         if (cmd == CMD_SWEEP) begin
            state_in = ST_SWEEP;
            seq_in   = '0;
            rrow_in  = '0;
            rcol_in  = '0;
            krow_in  = '0;
            kcol_in  = '0;
         end else begin
            rsp_valid_in   = 1'b1;
            rsp_max_in     = '0;
            rsp_conv_in    = 1'b0;
            rsp_is_read_in = (cmd == CMD_READ_CELL) && cell_in_range;
         end
      end

      // raster walk of the read and compute positions
      if (issuing) begin
         seq_in = seq_ff + 1'b1;
         if (tok.push) begin
            rcol_in = (rcol_ff == IDX_LAST) ? '0 : rcol_ff + 1'b1;
            rrow_in = (rcol_ff == IDX_LAST) ? rrow_ff + 1'b1 : rrow_ff;
         end
         if (tok.pos.valid) begin
            kcol_in = (kcol_ff == IDX_LAST) ? '0 : kcol_ff + 1'b1;
            krow_in = (kcol_ff == IDX_LAST) ? krow_ff + 1'b1 : krow_ff;
         end
      end

      // last cell written: swap banks and report
      if (done.valid) begin
         state_in       = ST_IDLE;
         bank_in        = ~bank_ff;
         sweeps_in      = (sweeps_ff == '1) ? sweeps_ff : sweeps_ff + 1'b1;
         rsp_valid_in   = 1'b1;
         rsp_max_in     = done.worst;
         rsp_conv_in    = done.worst <= tol_ff;
         rsp_is_read_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bank_ff        <= 1'b0;
         sweeps_ff      <= '0;
         tol_ff         <= TOL_RESET;
         rsp_valid_ff   <= 1'b0;
         rsp_max_ff     <= '0;
         rsp_conv_ff    <= 1'b0;
         rsp_is_read_ff <= 1'b0;
         seq_ff         <= '0;
         rrow_ff        <= '0;
         rcol_ff        <= '0;
         krow_ff        <= '0;
         kcol_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         bank_ff        <= bank_in;
         sweeps_ff      <= sweeps_in;
         tol_ff         <= tol_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_max_ff     <= rsp_max_in;
         rsp_conv_ff    <= rsp_conv_in;
         rsp_is_read_ff <= rsp_is_read_in;
         seq_ff         <= seq_in;
         rrow_ff        <= rrow_in;
         rcol_ff        <= rcol_in;
         krow_ff        <= krow_in;
         kcol_ff        <= kcol_in;
      end
   end

   // read data stays in the memory output register while the item waits
   always_comb begin
      rsp_if.valid       = rsp_valid_ff;
      rsp_if.read_value  = rsp_is_read_ff ? tile_rdata_ff : '0;
      rsp_if.max_change  = rsp_max_ff;
      rsp_if.converged   = rsp_conv_ff;
      rsp_if.sweep_count = sweeps_ff;
   end

   // checks
   `JTS_ASSERT_IMPLY(a_done_in_sweep, done.valid, state_ff == ST_SWEEP, "sweep end outside a sweep")
   `JTS_ASSERT_NEXT(a_bank_swap, done.valid, bank_ff != $past(bank_ff), "bank not swapped")
   `JTS_ASSERT_IMPLY(a_wr_other_bank, cell_wr.valid, tile_wr_addr[TILE_AW-1] != bank_ff, "sweep wrote current bank")
   `JTS_ASSERT_IMPLY(a_conv_tol, rsp_if.valid && rsp_if.converged, rsp_if.max_change <= tol_ff, "converged above tolerance")

endmodule

`default_nettype wire
